// ===== hw/rtl/oriented_box_overlap_test_unit_defines.svh =====
// Assertion macros for the overlap test unit checker.
`ifndef ORIENTED_BOX_OVERLAP_TEST_UNIT_DEFINES_SVH
`define ORIENTED_BOX_OVERLAP_TEST_UNIT_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge.
`define OBB_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("obb check failed");

// Next-cycle implication, sampled on the rising clock edge.
`define OBB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("obb check failed");

`endif

// ===== hw/rtl/obb_pkg.sv =====
// Package: widths, slot codes, MAC control struct and chunk helper for the overlap unit.
`timescale 1ns / 1ps
package obb_pkg;

  localparam int unsigned CompW     = 32;
  localparam int unsigned SlotCount = 10;
  localparam int unsigned ChunkW    = 34;
  localparam int unsigned ChunkN    = 3;
  localparam int unsigned LW        = ChunkW * ChunkN;
  localparam int unsigned ProdW     = 2 * ChunkW + 1;
  localparam int unsigned AccW      = 140;
  localparam int unsigned SizeShift = 17;
  localparam int unsigned FaceAxes  = 6;

  localparam logic [3:0] SlotRowB0   = 4'd3;
  localparam logic [3:0] SlotCenterA = 4'd6;
  localparam logic [3:0] SlotCenterB = 4'd7;
  localparam logic [3:0] SlotSizeA   = 4'd8;
  localparam logic [3:0] SlotSizeB   = 4'd9;
  localparam logic [3:0] LastAxis    = 4'd14;
  localparam logic [3:0] NoAxis      = 4'd15;

  typedef struct packed {
    logic       mul_en;
    logic       acc_en;
    logic       sub;
    logic [1:0] sh;
    logic       to_left;
    logic       clr_acc;
    logic       clr_left;
  } mac_ctrl_t;

  // Split a wide signed value into 34-bit chunks: low chunks unsigned, top chunk signed.
  function automatic logic signed [ChunkW:0] chunk_of(input logic [LW-1:0] x,
                                                      input logic [1:0]    h);
    logic signed [ChunkW:0] r;
    case (h)
      2'd0:    r = {1'b0, x[ChunkW-1:0]};
      2'd1:    r = {1'b0, x[2*ChunkW-1:ChunkW]};
      default: r = {x[LW-1], x[LW-1:2*ChunkW]};
    endcase
    return r;
  endfunction

endpackage

// ===== hw/rtl/oriented_box_overlap_test_unit.sv =====
// Top level: 3D oriented box overlap test by separating axes, on one shared MAC.
//
//   channel | direction | handshake             | payload
//   --------+-----------+-----------------------+------------------------------------------
//   in      | request   | in_valid_i/in_ready_o | slot_i, vec_x_i, vec_y_i, vec_z_i, evaluate_i
//   out     | result    | out_valid_o/out_ready_i | hit_o, axis_found_o
//
// A load request writes the vector to the three component RAMs.
// An evaluate request then runs the sequencer over the centre gap, each face axis and each
// edge axis in turn, stopping at the first separating axis. Every 35x34 multiply-accumulate
// on the single MAC goes through wait, multiply and accumulate phases.
// in_ready_o is low while the test runs; the result sits in an output register, so new
// loads are taken while it waits. Reset clears control only; the vector store holds
// whatever it held until each slot is written.
`timescale 1ns / 1ps
module oriented_box_overlap_test_unit (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic [3:0]                        slot_i,
  input  logic signed [obb_pkg::CompW-1:0]  vec_x_i,
  input  logic signed [obb_pkg::CompW-1:0]  vec_y_i,
  input  logic signed [obb_pkg::CompW-1:0]  vec_z_i,
  input  logic                              evaluate_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              hit_o,
  output logic [3:0]                        axis_found_o
);
  import obb_pkg::*;

  // Sequencer states.
  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_GAP   = 4'd1;
  localparam logic [3:0] ST_FACE  = 4'd2;
  localparam logic [3:0] ST_ROWA  = 4'd3;
  localparam logic [3:0] ST_CROSS = 4'd4;
  localparam logic [3:0] ST_DOT   = 4'd5;
  localparam logic [3:0] ST_SCALE = 4'd6;
  localparam logic [3:0] ST_EDOT  = 4'd7;
  localparam logic [3:0] ST_ABS   = 4'd8;
  localparam logic [3:0] ST_CMP   = 4'd9;

  // Phases of one MAC step: let the RAM address settle, multiply, accumulate.
  localparam logic [1:0] PH_WAIT = 2'd0;
  localparam logic [1:0] PH_MUL  = 2'd1;
  localparam logic [1:0] PH_ACC  = 2'd2;

  logic [3:0] state_q, state_d;
  logic [1:0] ph_q, ph_d;
  logic [3:0] axis_q, axis_d;
  logic [2:0] row_q, row_d;
  logic [1:0] k_q, k_d;
  logic [1:0] h_q, h_d;
  logic [1:0] ei_q, ei_d;
  logic [1:0] ej_q, ej_d;
  logic       out_valid_q, out_valid_d;
  logic       hit_q, hit_d;
  logic [3:0] found_q, found_d;

  logic [CompW:0]    g_q   [3];
  logic [CompW:0]    g_d   [3];
  logic [LW-1:0]     l_q   [3];
  logic [LW-1:0]     l_d   [3];
  logic [CompW-1:0]  buf_q [3];
  logic [CompW-1:0]  buf_d [3];
  logic [AccW-1:0]   eabs_q, eabs_d;

  logic [CompW-1:0]  wr [3];
  logic [CompW-1:0]  rd [3];
  logic              we;
  logic [3:0]        raddr;

  mac_ctrl_t                ctrl;
  logic signed [ChunkW:0]   op_a;
  logic signed [ChunkW-1:0] op_b;
  logic signed [AccW-1:0]   acc, left, sum;

  logic [1:0]        pa, pb, sc;
  logic [CompW-1:0]  s_raw;
  logic [ChunkW-1:0] s_ext, abs_s;
  logic              sep;

  // Vector store: one RAM per component, written together on a load request.
  assign wr[0] = vec_x_i;
  assign wr[1] = vec_y_i;
  assign wr[2] = vec_z_i;
  assign in_ready_o = (state_q == ST_IDLE);
  assign we = in_valid_i && in_ready_o && (slot_i < 4'(SlotCount));

  for (genvar c = 0; c < 3; c++) begin : g_comp
    obb_ram #(
      .Width (CompW),
      .Depth (SlotCount)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (we),
      .waddr_i (slot_i),
      .wdata_i (wr[c]),
      .raddr_i (raddr),
      .rdata_o (rd[c])
    );
  end

  obb_mac u_mac (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .ctrl_i (ctrl),
    .a_i    (op_a),
    .b_i    (op_b),
    .acc_o  (acc),
    .left_o (left),
    .sum_o  (sum)
  );

  // Cross product term picks: component c uses a[c+1]*b[c+2] then a[c+2]*b[c+1].
  always_comb begin
    case (k_q)
      2'd0:    begin pa = h_q[0] ? 2'd2 : 2'd1; pb = h_q[0] ? 2'd1 : 2'd2; end
      2'd1:    begin pa = h_q[0] ? 2'd0 : 2'd2; pb = h_q[0] ? 2'd2 : 2'd0; end
      default: begin pa = h_q[0] ? 2'd1 : 2'd0; pb = h_q[0] ? 2'd0 : 2'd1; end
    endcase
  end

  // Half-size scaling uses |s|; the halving itself is folded into the gap side.
  assign sc    = (row_q < 3'd3) ? row_q[1:0] : 2'(row_q - 3'd3);
  assign s_raw = rd[sc];
  assign s_ext = {{(ChunkW-CompW){s_raw[CompW-1]}}, s_raw};
  assign abs_s = s_raw[CompW-1] ? (-s_ext) : s_ext;

  assign sep = $unsigned(left) < (eabs_q << SizeShift);

  always_comb begin
    state_d     = state_q;
    ph_d        = ph_q;
    axis_d      = axis_q;
    row_d       = row_q;
    k_d         = k_q;
    h_d         = h_q;
    ei_d        = ei_q;
    ej_d        = ej_q;
    hit_d       = hit_q;
    found_d     = found_q;
    g_d         = g_q;
    l_d         = l_q;
    buf_d       = buf_q;
    eabs_d      = eabs_q;
    ctrl        = '0;
    raddr       = SlotCenterA;
    op_a        = '0;
    op_b        = '0;
    out_valid_d = out_valid_q && !out_ready_i;

    case (state_q)
      ST_IDLE: begin
        if (in_valid_i && evaluate_i) begin
          state_d = ST_GAP;
          ph_d    = PH_WAIT;
        end
      end

      // Gap = centre B - centre A, read one slot after the other.
      ST_GAP: begin
        raddr = (ph_q == PH_WAIT) ? SlotCenterA : SlotCenterB;
        case (ph_q)
          PH_WAIT: ph_d = PH_MUL;
          PH_MUL: begin
            for (int c = 0; c < 3; c++) g_d[c] = {rd[c][CompW-1], rd[c]};
            ph_d = PH_ACC;
          end
          default: begin
            for (int c = 0; c < 3; c++) g_d[c] = {rd[c][CompW-1], rd[c]} - g_q[c];
            ctrl.clr_acc  = 1'b1;
            ctrl.clr_left = 1'b1;
            axis_d  = '0;
            ei_d    = '0;
            ej_d    = '0;
            state_d = ST_FACE;
            ph_d    = PH_WAIT;
          end
        endcase
      end

      // Face axis: the candidate is an axis row as stored.
      ST_FACE: begin
        raddr = axis_q;
        if (ph_q == PH_WAIT) begin
          ph_d = PH_MUL;
        end else begin
          for (int c = 0; c < 3; c++) l_d[c] = {{(LW-CompW){rd[c][CompW-1]}}, rd[c]};
          row_d   = '0;
          k_d     = '0;
          h_d     = '0;
          state_d = ST_DOT;
          ph_d    = PH_WAIT;
        end
      end

      // Edge axis: hold row A i, then build A_i x B_j term by term.
      ST_ROWA: begin
        raddr = {2'b00, ei_q};
        if (ph_q == PH_WAIT) begin
          ph_d = PH_MUL;
        end else begin
          buf_d   = rd;
          k_d     = '0;
          h_d     = '0;
          state_d = ST_CROSS;
          ph_d    = PH_WAIT;
        end
      end

      ST_CROSS: begin
        raddr = SlotRowB0 + {2'b00, ej_q};
        op_a  = {{(ChunkW+1-CompW){buf_q[pa][CompW-1]}}, buf_q[pa]};
        op_b  = {{(ChunkW-CompW){rd[pb][CompW-1]}}, rd[pb]};
        case (ph_q)
          PH_WAIT: ph_d = PH_MUL;
          PH_MUL: begin
            ctrl.mul_en = 1'b1;
            ph_d        = PH_ACC;
          end
          default: begin
            ctrl.acc_en = 1'b1;
            ctrl.sub    = h_q[0];
            ph_d        = PH_WAIT;
            if (h_q[0]) begin
              l_d[k_q]     = sum[LW-1:0];
              ctrl.clr_acc = 1'b1;
              h_d          = '0;
              if (k_q == 2'd2) begin
                k_d     = '0;
                row_d   = '0;
                state_d = ST_DOT;
              end else begin
                k_d = k_q + 2'd1;
              end
            end else begin
              h_d = 2'd1;
            end
          end
        endcase
      end

      // d_j = L . n_j, in chunks of L against each component of row j.
      ST_DOT: begin
        raddr = {1'b0, row_q};
        op_a  = chunk_of(l_q[k_q], h_q);
        op_b  = {{(ChunkW-CompW){rd[k_q][CompW-1]}}, rd[k_q]};
        case (ph_q)
          PH_WAIT: ph_d = PH_MUL;
          PH_MUL: begin
            ctrl.mul_en = 1'b1;
            ph_d        = PH_ACC;
          end
          default: begin
            ctrl.acc_en = 1'b1;
            ctrl.sh     = h_q;
            ph_d        = PH_WAIT;
            if (h_q == 2'd2) begin
              h_d = '0;
              if (k_q == 2'd2) begin
                k_d     = '0;
                state_d = ST_SCALE;
              end else begin
                k_d = k_q + 2'd1;
              end
            end else begin
              h_d = h_q + 2'd1;
            end
          end
        endcase
      end

      // left += |d_j| * |s_j|: add or subtract by the sign of d_j.
      ST_SCALE: begin
        raddr = (row_q < 3'd3) ? SlotSizeA : SlotSizeB;
        op_a  = chunk_of(acc[LW-1:0], h_q);
        op_b  = abs_s;
        case (ph_q)
          PH_WAIT: ph_d = PH_MUL;
          PH_MUL: begin
            ctrl.mul_en = 1'b1;
            ph_d        = PH_ACC;
          end
          default: begin
            ctrl.acc_en  = 1'b1;
            ctrl.to_left = 1'b1;
            ctrl.sub     = acc[AccW-1];
            ctrl.sh      = h_q;
            ph_d         = PH_WAIT;
            if (h_q == 2'd2) begin
              h_d          = '0;
              ctrl.clr_acc = 1'b1;
              if (row_q == 3'(FaceAxes - 1)) begin
                k_d     = '0;
                state_d = ST_EDOT;
              end else begin
                row_d   = row_q + 3'd1;
                state_d = ST_DOT;
              end
            end else begin
              h_d = h_q + 2'd1;
            end
          end
        endcase
      end

      // e = L . gap
      ST_EDOT: begin
        op_a = chunk_of(l_q[k_q], h_q);
        op_b = {g_q[k_q][CompW], g_q[k_q]};
        case (ph_q)
          PH_WAIT: ph_d = PH_MUL;
          PH_MUL: begin
            ctrl.mul_en = 1'b1;
            ph_d        = PH_ACC;
          end
          default: begin
            ctrl.acc_en = 1'b1;
            ctrl.sh     = h_q;
            ph_d        = PH_WAIT;
            if (h_q == 2'd2) begin
              h_d = '0;
              if (k_q == 2'd2) begin
                k_d     = '0;
                state_d = ST_ABS;
              end else begin
                k_d = k_q + 2'd1;
              end
            end else begin
              h_d = h_q + 2'd1;
            end
          end
        endcase
      end

      ST_ABS: begin
        eabs_d  = acc[AccW-1] ? (-acc) : acc;
        state_d = ST_CMP;
      end

      // Separated when left < 2^17 * |e|; hold here while the last result waits.
      ST_CMP: begin
        if (sep || (axis_q == LastAxis)) begin
          if (!out_valid_q || out_ready_i) begin
            out_valid_d = 1'b1;
            hit_d       = !sep;
            found_d     = sep ? axis_q : NoAxis;
            state_d     = ST_IDLE;
          end
        end else begin
          axis_d        = axis_q + 4'd1;
          ctrl.clr_acc  = 1'b1;
          ctrl.clr_left = 1'b1;
          ph_d          = PH_WAIT;
          if (axis_q >= 4'(FaceAxes)) begin
            if (ej_q == 2'd2) begin
              ej_d = '0;
              ei_d = ei_q + 2'd1;
            end else begin
              ej_d = ej_q + 2'd1;
            end
          end
          state_d = (axis_q < 4'(FaceAxes - 1)) ? ST_FACE : ST_ROWA;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      ph_q        <= PH_WAIT;
      axis_q      <= '0;
      row_q       <= '0;
      k_q         <= '0;
      h_q         <= '0;
      ei_q        <= '0;
      ej_q        <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      ph_q        <= ph_d;
      axis_q      <= axis_d;
      row_q       <= row_d;
      k_q         <= k_d;
      h_q         <= h_d;
      ei_q        <= ei_d;
      ej_q        <= ej_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Datapath and result payload: no reset needed.
  always_ff @(posedge clk_i) begin
    hit_q   <= hit_d;
    found_q <= found_d;
    g_q     <= g_d;
    l_q     <= l_d;
    buf_q   <= buf_d;
    eabs_q  <= eabs_d;
  end

  assign out_valid_o  = out_valid_q;
  assign hit_o        = hit_q;
  assign axis_found_o = found_q;
endmodule

// ===== hw/rtl/obb_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module obb_ram #(
  parameter int unsigned Width = obb_pkg::CompW,
  parameter int unsigned Depth = obb_pkg::SlotCount
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;
endmodule

// ===== hw/rtl/obb_mac.sv =====
// Shared multiply-accumulate unit: one 35x34 product, then a shifted add or subtract into acc or left.
`timescale 1ns / 1ps
module obb_mac (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  obb_pkg::mac_ctrl_t                  ctrl_i,
  input  logic signed [obb_pkg::ChunkW:0]     a_i,
  input  logic signed [obb_pkg::ChunkW-1:0]   b_i,
  output logic signed [obb_pkg::AccW-1:0]     acc_o,
  output logic signed [obb_pkg::AccW-1:0]     left_o,
  output logic signed [obb_pkg::AccW-1:0]     sum_o
);
  import obb_pkg::*;

  logic signed [ProdW-1:0] prod_q;
  logic signed [AccW-1:0]  acc_q, acc_d, left_q, left_d;
  logic signed [AccW-1:0]  ext, addend, base, sum;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.mul_en) begin
      prod_q <= a_i * b_i;
    end
  end

  always_comb begin
    ext = AccW'(prod_q);
    case (ctrl_i.sh)
      2'd0:    addend = ext;
      2'd1:    addend = ext <<< ChunkW;
      default: addend = ext <<< (2 * ChunkW);
    endcase
    base = ctrl_i.to_left ? left_q : acc_q;
    sum  = ctrl_i.sub ? (base - addend) : (base + addend);

    acc_d = acc_q;
    if (ctrl_i.clr_acc) begin
      acc_d = '0;
    end else if (ctrl_i.acc_en && !ctrl_i.to_left) begin
      acc_d = sum;
    end
    left_d = left_q;
    if (ctrl_i.clr_left) begin
      left_d = '0;
    end else if (ctrl_i.acc_en && ctrl_i.to_left) begin
      left_d = sum;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q  <= '0;
      left_q <= '0;
    end else begin
      acc_q  <= acc_d;
      left_q <= left_d;
    end
  end

  assign acc_o  = acc_q;
  assign left_o = left_q;
  assign sum_o  = sum;
endmodule

// ===== hw/rtl/obb_checker.sv =====
// Port-level checker for the overlap test unit, bound to the top level.
`timescale 1ns / 1ps
`include "oriented_box_overlap_test_unit_defines.svh"
module obb_checker (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       in_valid_i,
  input logic       in_ready_o,
  input logic       evaluate_i,
  input logic       out_valid_o,
  input logic       out_ready_i,
  input logic       hit_o,
  input logic [3:0] axis_found_o
);
  import obb_pkg::*;

  `OBB_ASSERT_NEXT(a_busy_after_eval, clk_i, rst_ni, in_valid_i && in_ready_o && evaluate_i, !in_ready_o)
  `OBB_ASSERT_NEXT(a_load_keeps_ready, clk_i, rst_ni, in_valid_i && in_ready_o && !evaluate_i, in_ready_o)
  `OBB_ASSERT_NEXT(a_out_held, clk_i, rst_ni, out_valid_o && !out_ready_i, out_valid_o)
  `OBB_ASSERT_NOW(a_hit_no_axis, clk_i, rst_ni, out_valid_o, hit_o == (axis_found_o == NoAxis))
endmodule

bind oriented_box_overlap_test_unit obb_checker u_obb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_valid_i),
  .in_ready_o   (in_ready_o),
  .evaluate_i   (evaluate_i),
  .out_valid_o  (out_valid_o),
  .out_ready_i  (out_ready_i),
  .hit_o        (hit_o),
  .axis_found_o (axis_found_o)
);

// ===== tb/oriented_box_overlap_test_unit_tb.sv =====
// Testbench for the oriented box overlap unit: directed and random box scenes checked against an exact predictor.
`timescale 1ns / 1ps
module oriented_box_overlap_test_unit_tb;
  import obb_pkg::*;

  // Exact signed arithmetic, wide enough that no product or sum ever wraps.
  typedef logic signed [191:0] wide_t;

  typedef struct {
    logic       hit;
    logic [3:0] axis;
  } verdict_t;

  localparam int unsigned One = 32'h0001_0000;  // 1.0 in Q16.16

  // Scoreboard: mirrors the vector store and predicts the verdict of each evaluate.
  class overlap_scoreboard;
    logic signed [31:0] store [SlotCount*3];
    verdict_t           pending [$];
    int                 mismatches;
    wide_t              lv  [FaceAxes][3];
    wide_t              gap [3];

    function new();
      mismatches = 0;
      foreach (store[i]) store[i] = '0;
    endfunction

    function wide_t wcomp(int s, int k);
      logic signed [31:0] v;
      v = store[s*3+k];
      return {{160{v[31]}}, v};
    endfunction

    function wide_t wabs(wide_t x);
      return (x < 0) ? -x : x;
    endfunction

    // Separated when the summed box projections fall short of the doubled gap projection.
    function bit separates(wide_t a0, wide_t a1, wide_t a2);
      wide_t left;
      wide_t right;
      left = '0;
      for (int j = 0; j < FaceAxes; j++)
        left += wabs(a0*lv[j][0] + a1*lv[j][1] + a2*lv[j][2]);
      right = wabs(a0*gap[0] + a1*gap[1] + a2*gap[2]) <<< SizeShift;
      return left < right;
    endfunction

    function logic [3:0] first_axis();
      wide_t n [FaceAxes][3];
      wide_t s;
      for (int j = 0; j < FaceAxes; j++) begin
        s = wcomp((j < 3) ? SlotSizeA : SlotSizeB, j % 3);
        for (int k = 0; k < 3; k++) begin
          n[j][k]  = wcomp(j, k);
          lv[j][k] = n[j][k] * s;
        end
      end
      for (int k = 0; k < 3; k++) gap[k] = wcomp(SlotCenterB, k) - wcomp(SlotCenterA, k);
      for (int i = 0; i < FaceAxes; i++)
        if (separates(n[i][0], n[i][1], n[i][2])) return 4'(i);
      for (int i = 0; i < 3; i++)
        for (int j = 0; j < 3; j++)
          if (separates(n[i][1]*n[3+j][2] - n[i][2]*n[3+j][1],
                        n[i][2]*n[3+j][0] - n[i][0]*n[3+j][2],
                        n[i][0]*n[3+j][1] - n[i][1]*n[3+j][0]))
            return 4'(FaceAxes + 3*i + j);
      return NoAxis;
    endfunction

    function void note_request(logic [3:0] slot, logic signed [31:0] x, logic signed [31:0] y,
                               logic signed [31:0] z, logic eval);
      verdict_t v;
      if (slot < SlotCount) begin
        store[slot*3]   = x;
        store[slot*3+1] = y;
        store[slot*3+2] = z;
      end
      if (eval) begin
        v.axis = first_axis();
        v.hit  = (v.axis == NoAxis);
        pending.push_back(v);
      end
    endfunction

    function void check_result(logic hit, logic [3:0] axis);
      verdict_t v;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result: hit %0d axis %0d", hit, axis);
        return;
      end
      v = pending.pop_front();
      if (hit !== v.hit || axis !== v.axis) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected hit %0d axis %0d, got hit %0d axis %0d",
                   v.hit, v.axis, hit, axis);
      end
    endfunction
  endclass

  logic               clk_i;
  logic               rst_ni;
  logic               in_valid_i;
  logic               in_ready_o;
  logic [3:0]         slot_i;
  logic signed [31:0] vec_x_i;
  logic signed [31:0] vec_y_i;
  logic signed [31:0] vec_z_i;
  logic               evaluate_i;
  logic               out_valid_o;
  logic               out_ready_i;
  logic               hit_o;
  logic [3:0]         axis_found_o;

  overlap_scoreboard sb;
  bit                steady;   // no idling on either side while set
  int                sent;
  int signed         centre_a [3];

  oriented_box_overlap_test_unit dut (.*);

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Give up long after the slowest correct run would have ended.
  initial begin
    #200ms;
    $display("TEST FAILED");
    $finish;
  end

  // Result side: hold ready low with a chance of 14 in a hundred outside the steady phase, check every accepted result.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else begin
      if (out_valid_o && out_ready_i) sb.check_result(hit_o, axis_found_o);
      out_ready_i <= steady || ($urandom_range(0, 99) >= 14);
    end
  end

  // Hold the request until accepted, then record it.
  task automatic send_request(logic [3:0] slot, logic signed [31:0] x, logic signed [31:0] y,
                              logic signed [31:0] z, logic eval);
    if (!steady && $urandom_range(0, 99) < 14) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    slot_i     <= slot;
    vec_x_i    <= x;
    vec_y_i    <= y;
    vec_z_i    <= z;
    evaluate_i <= eval;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_request(slot, x, y, z, eval);
    sent++;
  endtask

  task automatic load_identity_scene(int signed gap_x);
    send_request(0, One, 0, 0, 1'b0);
    send_request(1, 0, One, 0, 1'b0);
    send_request(2, 0, 0, One, 1'b0);
    send_request(SlotRowB0, One, 0, 0, 1'b0);
    send_request(4'(SlotRowB0 + 4'd1), 0, One, 0, 1'b0);
    send_request(4'(SlotRowB0 + 4'd2), 0, 0, One, 1'b0);
    send_request(SlotCenterA, 0, 0, 0, 1'b0);
    send_request(SlotSizeA, 2*One, 2*One, 2*One, 1'b0);
    send_request(SlotSizeB, 2*One, 2*One, 2*One, 1'b0);
    send_request(SlotCenterB, gap_x, 0, 0, 1'b1);
  endtask

  // Scene component for one slot: row components in [-1.0, 1.0], sizes up to 4.0 in magnitude, centres near.
  function automatic int signed scene_comp(int slot, int k);
    int signed v;
    if (slot < 6) begin
      v = $urandom_range(0, 2) == 0 ? ($urandom_range(0, 1) ? One : -One) * ($urandom_range(0, 1))
                                    : int'($urandom_range(0, 2*One)) - int'(One);
    end else if (slot == SlotCenterA) begin
      v = centre_a[k];
    end else if (slot == SlotCenterB) begin
      v = centre_a[k] + int'($urandom_range(0, 12*One)) - int'(6*One);
    end else begin
      v = $urandom_range(0, 4*One);
      if ($urandom_range(0, 9) == 0) v = -v;  // negative size acts as its magnitude
    end
    return v;
  endfunction

  initial begin
    int  order [10];
    int  count;
    int  tmp;
    int  idx;
    bit  eval;
    sb          = new();
    steady      = 1'b0;
    sent        = 0;
    rst_ni      = 1'b0;
    in_valid_i  = 1'b0;
    slot_i      = '0;
    vec_x_i     = '0;
    vec_y_i     = '0;
    vec_z_i     = '0;
    evaluate_i  = 1'b0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: overlapping aligned boxes (parallel edges), then separation on face x.
    load_identity_scene(One);
    send_request(SlotCenterB, 5*One, 0, 0, 1'b1);
    // Tilt A in the xy plane; the z face of A separates.
    send_request(0, One, One, 0, 1'b0);
    send_request(1, -One, One, 0, 1'b0);
    send_request(SlotCenterB, 0, 0, 5*One, 1'b1);
    // Negative sizes, extreme components, unused slots with and without evaluate.
    send_request(SlotSizeA, -2*One, -2*One, -2*One, 1'b1);
    send_request(SlotCenterA, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 1'b1);
    send_request(SlotCenterB, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_request(SlotRowB0, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 1'b1);
    send_request(4'd10, 32'hFFFF_FFFF, 0, 32'hFFFF_FFFF, 1'b1);
    send_request(4'd15, 0, 32'hFFFF_FFFF, 0, 1'b0);
    send_request(SlotSizeB, 32'h7FFF_FFFF, 32'h8000_0000, 0, 1'b1);

    // Random: mostly scenes loaded slot by slot and then evaluated, some raw noise.
    while (sent < 1500) begin
      steady = (sent >= 600 && sent < 900);
      if ($urandom_range(0, 99) < 15) begin
        send_request(4'($urandom), $urandom, $urandom, $urandom, $urandom_range(0, 7) == 0);
      end else begin
        for (int k = 0; k < 3; k++) centre_a[k] = int'($urandom_range(0, 8*One)) - int'(4*One);
        foreach (order[i]) order[i] = i;
        for (int i = 9; i > 0; i--) begin
          idx = $urandom_range(0, i);
          tmp = order[i]; order[i] = order[idx]; order[idx] = tmp;
        end
        count = $urandom_range(1, 10);
        for (int i = 0; i < count; i++) begin
          eval = (i == count - 1);
          send_request(4'(order[i]), scene_comp(order[i], 0), scene_comp(order[i], 1),
                       scene_comp(order[i], 2), eval);
        end
      end
    end
    steady = 1'b0;
    in_valid_i <= 1'b0;

    // Drain outstanding verdicts, then allow a short settle.
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/obb_pkg.sv
hw/rtl/obb_ram.sv
hw/rtl/obb_mac.sv
hw/rtl/oriented_box_overlap_test_unit.sv
hw/rtl/obb_checker.sv
tb/oriented_box_overlap_test_unit_tb.sv
